// ===== rtl/blit_texture_address_generator_assert.svh =====
// Assertion macros shared by the blit texture address generator.
`ifndef BLIT_TEXTURE_ADDRESS_GENERATOR_ASSERT_SVH
`define BLIT_TEXTURE_ADDRESS_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BTAG_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("btag: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define BTAG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("btag: next-cycle check failed");

`endif

// ===== rtl/btag_pkg.sv =====
// Package: types, register indexes and mode codes of the blit address generator.
`timescale 1ns / 1ps

package btag_pkg;

    localparam int COORD_BITS     = 12;
    localparam int OFF_BITS       = 12;
    localparam int REG_BITS       = 24;
    localparam int ADDR_BITS      = 24;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ADDRESS_MODE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_RECT_ORIGIN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_RECT_SIZE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_RECT_ORIGIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_RECT_SIZE     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_IMAGE_SIZE  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_IMAGE_SIZE    = 3'd6;

    typedef enum logic [2:0] {
        MODE_NONE    = 3'd0,
        MODE_WRAP    = 3'd1,
        MODE_CLAMP   = 3'd2,
        MODE_MIRROR  = 3'd3,
        MODE_STRETCH = 3'd4
    } addr_mode_t;

    typedef struct packed {
        logic [OFF_BITS-1:0] offset_x;
        logic [OFF_BITS-1:0] offset_y;
    } in_item_t;

    typedef struct packed {
        logic                 write_enable;
        logic [ADDR_BITS-1:0] dest_address;
        logic [ADDR_BITS-1:0] source_address;
        logic                 source_in_range;
    } out_item_t;

endpackage

// ===== rtl/btag_axis.sv =====
// One axis of the source coordinate: two bit-serial divider pipelines and mode select.
`timescale 1ns / 1ps

module btag_axis
    import btag_pkg::*;
#(
    parameter int CB  = COORD_BITS,
    parameter int OFF = OFF_BITS
)
(
    input  logic           clk,
    input  logic           adv,
    input  addr_mode_t     mode,
    input  logic [OFF-1:0] offset,
    input  logic [CB-1:0]  org,
    input  logic [CB-1:0]  rsize,
    input  logic [CB-1:0]  dsize,
    input  logic [CB-1:0]  isize,
    output logic [CB-1:0]  coord,
    output logic           in_image
);

    localparam int CW = ((CB > OFF) ? CB : OFF) + 1;
    localparam int N1 = OFF + CB;
    localparam int D1 = CB + 1;
    localparam int N2 = CB + 2;
    localparam int D2 = CB;
    localparam int SW = N1 + 1;

    logic [CW-1:0]  c0_reg;
    logic [N1-1:0]  p0_reg;
    logic [OFF-1:0] off0_reg;

    logic [D1-1:0] r1_reg  [N1];
    logic [N1-1:0] rq1_reg [N1];
    logic [CW-1:0] c1_reg  [N1];

    logic [D2-1:0] r2_reg  [N2];
    logic [N2-1:0] rq2_reg [N2];
    logic [CW-1:0] c2_reg  [N2];
    logic [D1-1:0] m1_reg  [N2];
    logic [N1-1:0] q1_reg  [N2];

    logic [CB-1:0] coord_reg;
    logic          inside_reg;

    logic [D1-1:0] div1;
    logic [N1-1:0] dsel;
    logic [CB-1:0] wrap_m1;
    logic [N2-1:0] dend2;
    logic [SW-1:0] s_next;

    function automatic logic [D1+N1-1:0] step1(input logic [D1-1:0] r,
                                               input logic [N1-1:0] rq,
                                               input logic [D1-1:0] d);
        logic [D1:0]   t;
        logic [N1-1:0] q;
        t = {r, rq[N1-1]};
        q = {rq[N1-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            t    = t - {1'b0, d};
            q[0] = 1'b1;
        end
        return {t[D1-1:0], q};
    endfunction

    function automatic logic [D2+N2-1:0] step2(input logic [D2-1:0] r,
                                               input logic [N2-1:0] rq,
                                               input logic [D2-1:0] d);
        logic [D2:0]   t;
        logic [N2-1:0] q;
        t = {r, rq[N2-1]};
        q = {rq[N2-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            t    = t - {1'b0, d};
            q[0] = 1'b1;
        end
        return {t[D2-1:0], q};
    endfunction

    function automatic logic [SW-1:0] clamp_top(input logic [SW-1:0] v,
                                                input logic [CB-1:0] sz);
        logic [SW-1:0] top;
        top = SW'(sz) - SW'(1);
        if (sz == '0)
            return '0;
        return (v > top) ? top : v;
    endfunction

    // Divisor and dividend of the first divider follow the mode
    always_comb
    begin
        div1 = {1'b0, dsize};
        dsel = p0_reg;
        case (mode)
            MODE_WRAP:
            begin
                div1 = {1'b0, isize};
                dsel = N1'(off0_reg);
            end
            MODE_MIRROR:
            begin
                div1 = {isize, 1'b0};
                dsel = N1'(c0_reg);
            end
            default:
            begin
                div1 = {1'b0, dsize};
                dsel = p0_reg;
            end
        endcase
    end

    assign wrap_m1 = (isize == '0) ? '0 : r1_reg[N1-1][CB-1:0];
    assign dend2   = N2'(org) + N2'(wrap_m1) + N2'(rsize);

    // Final per-mode selection
    always_comb
    begin
        logic [N1-1:0] q;
        logic [N1-1:0] t;
        logic [D1-1:0] r;
        q = (dsize == '0) ? '0 : q1_reg[N2-1];
        t = (q == '0) ? '0 : q - N1'(1);
        r = m1_reg[N2-1];
        case (mode)
            MODE_WRAP:
                s_next = (rsize == '0) ? '0 : SW'(r2_reg[N2-1]);
            MODE_CLAMP:
                s_next = clamp_top(SW'(c2_reg[N2-1]), isize);
            MODE_MIRROR:
            begin
                if (isize == '0)
                    s_next = '0;
                else if (r >= {1'b0, isize})
                    s_next = SW'({isize, 1'b0} - r - D1'(1));
                else
                    s_next = SW'(r);
            end
            MODE_STRETCH:
                s_next = clamp_top(SW'(org) + SW'(t), isize);
            default:
                s_next = SW'(c2_reg[N2-1]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off0_reg <= offset;
            c0_reg   <= CW'(org) + CW'(offset);
            p0_reg   <= N1'(offset) * N1'(rsize);

            {r1_reg[0], rq1_reg[0]} <= step1('0, dsel, div1);
            c1_reg[0] <= c0_reg;
            for (int j = 1; j < N1; j++)
            begin
                {r1_reg[j], rq1_reg[j]} <= step1(r1_reg[j-1], rq1_reg[j-1], div1);
                c1_reg[j] <= c1_reg[j-1];
            end

            {r2_reg[0], rq2_reg[0]} <= step2('0, dend2, rsize);
            c2_reg[0] <= c1_reg[N1-1];
            m1_reg[0] <= r1_reg[N1-1];
            q1_reg[0] <= rq1_reg[N1-1];
            for (int j = 1; j < N2; j++)
            begin
                {r2_reg[j], rq2_reg[j]} <= step2(r2_reg[j-1], rq2_reg[j-1], rsize);
                c2_reg[j] <= c2_reg[j-1];
                m1_reg[j] <= m1_reg[j-1];
                q1_reg[j] <= q1_reg[j-1];
            end

            coord_reg  <= s_next[CB-1:0];
            inside_reg <= (s_next < SW'(isize));
        end
    end

    assign coord    = coord_reg;
    assign in_image = inside_reg;

endmodule

// ===== rtl/blit_texture_address_generator.sv =====
// Top level: blit texture address generator with config registers and output skid.
//
//  channel   | signals                          | moves
//  ----------+----------------------------------+--------------------------------
//  item      | item_valid, item_ready, item     | destination offset x, y
//  result    | result_valid, result_ready, result| enable, dest/source address, flag
//  cfg       | cfg_valid, cfg_ready, cfg_index, | one register write
//            | cfg_data                         |
//
// One item is taken per cycle while item_ready is high. Most of the pipeline is the two
// bit-serial divider chains per axis, one quotient bit per stage: offset/size or
// product/size, then the wrap remainder; around them sit the entry stage, the mode select,
// the address products and the output register. Reset clears all configuration registers
// and every valid bit at once.
// A stalled result holds in the output register and the next one drops into a skid
// register; only with the skid full does the whole pipeline hold and item_ready fall.
`timescale 1ns / 1ps

module blit_texture_address_generator
    import btag_pkg::*;
#(
    parameter int COORD_BITS = btag_pkg::COORD_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  in_item_t                  item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output out_item_t                 result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data
);

`include "blit_texture_address_generator_assert.svh"

    localparam int CB  = COORD_BITS;
    localparam int CW  = ((CB > OFF_BITS) ? CB : OFF_BITS) + 1;
    localparam int NAX = (OFF_BITS + CB) + (CB + 2) + 2;
    localparam int NST = NAX + 1;
    localparam int RW  = (2 * CB > REG_BITS) ? 2 * CB : REG_BITS;
    localparam int AW  = (CW + CB + 1 > ADDR_BITS + 1) ? CW + CB + 1 : ADDR_BITS + 1;

    // Configuration registers
    addr_mode_t          mode_reg;
    logic [REG_BITS-1:0] src_org_reg;
    logic [REG_BITS-1:0] src_rsize_reg;
    logic [REG_BITS-1:0] dst_org_reg;
    logic [REG_BITS-1:0] dst_rsize_reg;
    logic [REG_BITS-1:0] src_isize_reg;
    logic [REG_BITS-1:0] dst_isize_reg;

    // Pipeline control
    logic [NST-1:0] valid_reg;
    logic           adv;
    logic           incoming;

    // Destination path carried alongside the source axes
    logic [CW-1:0] dx_reg [NAX];
    logic [CW-1:0] dy_reg [NAX];
    logic          we_reg [NAX];
    out_item_t     fin_reg;

    // Output register and skid
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t skid_reg;
    logic      skid_valid_reg;

    logic [RW-1:0] src_org_x;
    logic [RW-1:0] src_rsize_x;
    logic [RW-1:0] dst_org_x;
    logic [RW-1:0] dst_rsize_x;
    logic [RW-1:0] src_isize_x;
    logic [RW-1:0] dst_isize_x;

    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic          in_x;
    logic          in_y;
    logic [CW-1:0] dx0;
    logic [CW-1:0] dy0;
    logic [AW-1:0] dest_sum;
    logic [AW-1:0] src_sum;
    out_item_t     fin_next;

    assign src_org_x   = RW'(src_org_reg);
    assign src_rsize_x = RW'(src_rsize_reg);
    assign dst_org_x   = RW'(dst_org_reg);
    assign dst_rsize_x = RW'(dst_rsize_reg);
    assign src_isize_x = RW'(src_isize_reg);
    assign dst_isize_x = RW'(dst_isize_reg);

    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NONE;
            src_org_reg   <= '0;
            src_rsize_reg <= '0;
            dst_org_reg   <= '0;
            dst_rsize_reg <= '0;
            src_isize_reg <= '0;
            dst_isize_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ADDRESS_MODE:       mode_reg      <= addr_mode_t'(cfg_data[2:0]);
                REG_SOURCE_RECT_ORIGIN: src_org_reg   <= cfg_data;
                REG_SOURCE_RECT_SIZE:   src_rsize_reg <= cfg_data;
                REG_DEST_RECT_ORIGIN:   dst_org_reg   <= cfg_data;
                REG_DEST_RECT_SIZE:     dst_rsize_reg <= cfg_data;
                REG_SOURCE_IMAGE_SIZE:  src_isize_reg <= cfg_data;
                REG_DEST_IMAGE_SIZE:    dst_isize_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Advance the whole pipeline unless the skid is occupied
    assign adv        = !skid_valid_reg;
    assign item_ready = adv;
    assign incoming   = valid_reg[NST-1] && adv;

    btag_axis #(.CB(CB), .OFF(OFF_BITS)) u_axis_x (
        .clk      (clk),
        .adv      (adv),
        .mode     (mode_reg),
        .offset   (item.offset_x),
        .org      (src_org_x[CB-1:0]),
        .rsize    (src_rsize_x[CB-1:0]),
        .dsize    (dst_rsize_x[CB-1:0]),
        .isize    (src_isize_x[CB-1:0]),
        .coord    (sx),
        .in_image (in_x)
    );

    btag_axis #(.CB(CB), .OFF(OFF_BITS)) u_axis_y (
        .clk      (clk),
        .adv      (adv),
        .mode     (mode_reg),
        .offset   (item.offset_y),
        .org      (src_org_x[2*CB-1:CB]),
        .rsize    (src_rsize_x[2*CB-1:CB]),
        .dsize    (dst_rsize_x[2*CB-1:CB]),
        .isize    (src_isize_x[2*CB-1:CB]),
        .coord    (sy),
        .in_image (in_y)
    );

    assign dx0 = CW'(dst_org_x[CB-1:0]) + CW'(item.offset_x);
    assign dy0 = CW'(dst_org_x[2*CB-1:CB]) + CW'(item.offset_y);

    // Final stage: both address products, zeroed when the write is off
    always_comb
    begin
        dest_sum = AW'(dy_reg[NAX-1]) * AW'(dst_isize_x[CB-1:0]) + AW'(dx_reg[NAX-1]);
        src_sum  = AW'(sy) * AW'(src_isize_x[CB-1:0]) + AW'(sx);
        fin_next.write_enable    = we_reg[NAX-1];
        fin_next.dest_address    = we_reg[NAX-1] ? dest_sum[ADDR_BITS-1:0] : '0;
        fin_next.source_in_range = we_reg[NAX-1] && in_x && in_y;
        fin_next.source_address  = fin_next.source_in_range ?
                                   src_sum[ADDR_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NST-2:0], item_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0] <= dx0;
            dy_reg[0] <= dy0;
            we_reg[0] <= (dx0 < CW'(dst_isize_x[CB-1:0])) &&
                         (dy0 < CW'(dst_isize_x[2*CB-1:CB]));
            for (int k = 1; k < NAX; k++)
            begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
                we_reg[k] <= we_reg[k-1];
            end
            fin_reg <= fin_next;
        end
    end

    // Output register with one-entry skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (result_ready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || incoming;
            skid_valid_reg <= 1'b0;
        end
        else if (incoming)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (result_ready || !out_valid_reg)
            out_reg <= skid_valid_reg ? skid_reg : fin_reg;
        else if (incoming)
            skid_reg <= fin_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The skid only fills behind a held result
    `BTAG_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A full skid keeps its entry until the output moves
    `BTAG_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && !result_ready, skid_valid_reg)
    // A transfer in always enters the first stage
    `BTAG_ASSERT_NEXT(a_item_enters, clk, rst_n, item_valid && item_ready, valid_reg[0])

endmodule
